>>> hdl/bi1_pkg.sv
// bi1_pkg: types, constants and coefficient tables for the I1(x) pipeline
// depends on nothing; imported by bessel_i1_approx
package bi1_pkg;

   // range split and exponent constants
   localparam logic [21:0] ThreshQ16 = 22'd245760;
   localparam logic [47:0] LargeNum  = 48'd263882790666240;   // 245760 * 2^30
   localparam logic [21:0] SmallDen  = 22'd225;
   localparam logic [47:0] SmallRnd  = 48'd112;
   localparam logic [25:0] ExpBias   = 26'd60801;
   localparam logic [42:0] InvLn2    = 43'd6345039891169;     // 16/ln2 in Q38
   localparam logic [5:0]  ExpShift  = 6'd14;

   // pipeline depths
   localparam int DivSteps  = 31;   // quotient bits of y
   localparam int SqrtSteps = 27;   // root bits of sqrt(a * 2^32)
   localparam int HornSteps = 8;
   localparam int Div2Steps = 39;   // quotient bits of d

   // Q30 polynomial coefficients, index = power of y; unused terms are zero
   localparam logic signed [33:0] SmallPoly [9] = '{
      34'sd536870912, 34'sd943718067, 34'sd552964895, 34'sd161973245,
      34'sd28547928, 34'sd3237675, 34'sd348010, 34'sd0, 34'sd0
   };
   localparam logic signed [33:0] LargePoly [9] = '{
      34'sd428361011, -34'sd42821082, -34'sd3887139, 34'sd1758800,
      -34'sd11076237, 34'sd24513172, -34'sd31088176, 34'sd19194789,
      -34'sd4510349
   };

   typedef struct packed {
      logic        vld;
      logic        neg;
      logic [21:0] a;
   } in_stage_type;

   typedef struct packed {
      logic        vld;
      logic        neg;
      logic        is_small;
      logic [21:0] a;
      logic [47:0] rem;
      logic [21:0] den;
      logic [30:0] quo;
      logic [53:0] sv;
      logic [53:0] sr;
      logic [43:0] plo;
      logic [42:0] phi;
      logic [25:0] e;
   } div_stage_type;

   typedef struct packed {
      logic               vld;
      logic               neg;
      logic               is_small;
      logic [21:0]        a;
      logic [25:0]        e;
      logic [26:0]        s;
      logic [30:0]        y;
      logic signed [33:0] acc;
      logic               psgn;
      logic [63:0]        prod;
   } horn_stage_type;

   typedef struct packed {
      logic        vld;
      logic        neg;
      logic        is_small;
      logic [5:0]  k;
      logic [26:0] s;
      logic [53:0] prod;
   } mul_stage_type;

   typedef struct packed {
      logic        vld;
      logic        neg;
      logic        is_small;
      logic [5:0]  k;
      logic [63:0] mag;
      logic [26:0] s;
      logic [62:0] rem;
      logic [38:0] quo;
   } div2_stage_type;

   typedef struct packed {
      logic        vld;
      logic        neg;
      logic        sat;
      logic [63:0] mag;
   } out_stage_type;

endpackage

>>> hdl/bessel_i1_approx.sv
// bessel_i1_approx: pipelined I1(x), Q5.16 in, Q39.24 out, saturating
// depends on bi1_pkg
//
//   channel | ports                               | direction
//   request | req_valid req_stall req_x_value     | in
//   result  | rsp_valid rsp_stall rsp_i1_value    | out
//           | rsp_saturated                       |
//
// one request per cycle while not stalled, 93 register stages; the depth is
// set by the 31-stage restoring divider for y, the 16-stage Horner chain and
// the 39-stage divider by sqrt(|x|). the whole pipeline holds while a result
// waits under rsp_stall; req_stall follows.
// synchronous reset clears the valid bits.
module bessel_i1_approx
   import bi1_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  logic signed [21:0] req_x_value,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic signed [63:0] rsp_i1_value,
   output logic               rsp_saturated
);

   logic adv;

   in_stage_type   a_ff, a_in;
   div_stage_type  d_ff [DivSteps+1];
   div_stage_type  d_in [DivSteps+1];
   horn_stage_type h_ff [2*HornSteps+1];
   horn_stage_type h_in [2*HornSteps+1];
   mul_stage_type  f1_ff, f1_in;
   div2_stage_type q_ff [Div2Steps+1];
   div2_stage_type q_in [Div2Steps+1];
   out_stage_type  f3_ff, f3_in;
   out_stage_type  o_ff, o_in;

   // global advance: everything moves unless the result is held
   assign adv       = !(o_ff.vld && rsp_stall);
   assign req_stall = !adv;

   // input: sign and magnitude
   always_comb begin
      a_in.vld = req_valid;
      a_in.neg = req_x_value[21];
      a_in.a   = req_x_value[21] ? (~req_x_value + 22'd1) : req_x_value;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_ff.vld <= 1'b0;
      end else if (adv) begin
         a_ff <= a_in;
      end
   end

   // setup: divider operands, sqrt radicand, exponent partial products
   always_comb begin
      logic [43:0] sq;
      sq = 44'(a_ff.a) * 44'(a_ff.a);
      d_in[0].vld      = a_ff.vld;
      d_in[0].neg      = a_ff.neg;
      d_in[0].is_small = a_ff.a < ThreshQ16;
      d_in[0].a        = a_ff.a;
      d_in[0].rem      = d_in[0].is_small ? (48'({sq, 2'b00}) + SmallRnd) : LargeNum;
      d_in[0].den      = d_in[0].is_small ? SmallDen : a_ff.a;
      d_in[0].quo      = '0;
      d_in[0].sv       = {a_ff.a, 32'd0};
      d_in[0].sr       = '0;
      d_in[0].plo      = 44'(a_ff.a) * 44'(InvLn2[21:0]);
      d_in[0].phi      = 43'(a_ff.a) * 43'(InvLn2[42:22]);
      d_in[0].e        = '0;
   end

   // divider for y, sqrt and exponent running side by side
   for (genvar j = 0; j < DivSteps; j++) begin : g_div
      localparam int QBit  = DivSteps - 1 - j;
      localparam int SqBit = (j < SqrtSteps) ? 2 * (SqrtSteps - 1 - j) : 0;
      always_comb begin
         logic [52:0] trial;
         logic [53:0] bitv;
         logic [53:0] rb;
         logic [64:0] kp;
         d_in[j+1] = d_ff[j];
         trial = 53'(d_ff[j].den) << QBit;
         if ({5'd0, d_ff[j].rem} >= trial) begin
            d_in[j+1].rem       = d_ff[j].rem - trial[47:0];
            d_in[j+1].quo[QBit] = 1'b1;
         end
         bitv = 54'd1 << SqBit;
         rb   = d_ff[j].sr + bitv;
         if (j < SqrtSteps) begin
            if (d_ff[j].sv >= rb) begin
               d_in[j+1].sv = d_ff[j].sv - rb;
               d_in[j+1].sr = (d_ff[j].sr >> 1) + bitv;
            end else begin
               d_in[j+1].sr = d_ff[j].sr >> 1;
            end
         end
         kp = {d_ff[j].phi, 22'd0} + 65'(d_ff[j].plo);
         if (j == 0) begin
            d_in[j+1].e = 26'(kp >> 38) - ExpBias;
         end
      end
   end

   for (genvar j = 0; j <= DivSteps; j++) begin : g_div_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            d_ff[j].vld <= 1'b0;
         end else if (adv) begin
            d_ff[j] <= d_in[j];
         end
      end
   end

   // horner seed: leading coefficient
   always_comb begin
      h_in[0].vld      = d_ff[DivSteps].vld;
      h_in[0].neg      = d_ff[DivSteps].neg;
      h_in[0].is_small = d_ff[DivSteps].is_small;
      h_in[0].a        = d_ff[DivSteps].a;
      h_in[0].e        = d_ff[DivSteps].e;
      h_in[0].s        = d_ff[DivSteps].sr[26:0];
      h_in[0].y        = d_ff[DivSteps].quo;
      h_in[0].acc      = d_ff[DivSteps].is_small ? SmallPoly[HornSteps]
                                                 : LargePoly[HornSteps];
      h_in[0].psgn     = 1'b0;
      h_in[0].prod     = '0;
   end

   // horner steps: multiply stage then round-and-add stage
   for (genvar n = 0; n < HornSteps; n++) begin : g_horn
      localparam int CIdx = HornSteps - 1 - n;
      always_comb begin
         logic [33:0] amag;
         amag = h_ff[2*n].acc[33] ? 34'(-h_ff[2*n].acc) : 34'(h_ff[2*n].acc);
         h_in[2*n+1]      = h_ff[2*n];
         h_in[2*n+1].psgn = h_ff[2*n].acc[33];
         h_in[2*n+1].prod = 64'(amag[32:0]) * 64'(h_ff[2*n].y);
      end
      always_comb begin
         logic [63:0]        rnd;
         logic signed [33:0] term;
         logic signed [33:0] coef;
         rnd  = (h_ff[2*n+1].prod + 64'(1 << 29)) >> 30;
         term = $signed({1'b0, rnd[32:0]});
         coef = h_ff[2*n+1].is_small ? SmallPoly[CIdx] : LargePoly[CIdx];
         h_in[2*n+2]     = h_ff[2*n+1];
         h_in[2*n+2].acc = h_ff[2*n+1].psgn ? (coef - term) : (coef + term);
      end
   end

   for (genvar j = 0; j <= 2 * HornSteps; j++) begin : g_horn_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            h_ff[j].vld <= 1'b0;
         end else if (adv) begin
            h_ff[j] <= h_in[j];
         end
      end
   end

   // shared multiply: x * P, or (1 + m) * Q for the exponent mantissa
   always_comb begin
      logic [21:0] opa;
      logic [31:0] opb;
      logic [33:0] qq;
      qq  = h_ff[2*HornSteps].acc[33] ? 34'd0 : 34'(h_ff[2*HornSteps].acc);
      opa = h_ff[2*HornSteps].is_small ? h_ff[2*HornSteps].a
                                       : {2'b01, h_ff[2*HornSteps].e[19:0]};
      opb = h_ff[2*HornSteps].is_small ? h_ff[2*HornSteps].acc[31:0] : qq[31:0];
      f1_in.vld      = h_ff[2*HornSteps].vld;
      f1_in.neg      = h_ff[2*HornSteps].neg;
      f1_in.is_small = h_ff[2*HornSteps].is_small;
      f1_in.k        = h_ff[2*HornSteps].e[25:20];
      f1_in.s        = h_ff[2*HornSteps].s;
      f1_in.prod     = 54'(opa) * 54'(opb);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f1_ff.vld <= 1'b0;
      end else if (adv) begin
         f1_ff <= f1_in;
      end
   end

   // small-range rounding and second divider setup
   always_comb begin
      logic [53:0] rs;
      rs = (f1_ff.prod + 54'(1 << 21)) >> 22;
      q_in[0].vld      = f1_ff.vld;
      q_in[0].neg      = f1_ff.neg;
      q_in[0].is_small = f1_ff.is_small;
      q_in[0].k        = f1_ff.k;
      q_in[0].mag      = 64'(rs);
      q_in[0].s        = f1_ff.s;
      q_in[0].rem      = {f1_ff.prod[50:0], 12'd0};
      q_in[0].quo      = '0;
   end

   // divider by sqrt(|x|)
   for (genvar j = 0; j < Div2Steps; j++) begin : g_div2
      localparam int QBit = Div2Steps - 1 - j;
      always_comb begin
         logic [65:0] trial;
         q_in[j+1] = q_ff[j];
         trial = 66'(q_ff[j].s) << QBit;
         if ({3'd0, q_ff[j].rem} >= trial) begin
            q_in[j+1].rem       = q_ff[j].rem - trial[62:0];
            q_in[j+1].quo[QBit] = 1'b1;
         end
      end
   end

   for (genvar j = 0; j <= Div2Steps; j++) begin : g_div2_reg
      always_ff @(posedge clock) begin
         if (reset) begin
            q_ff[j].vld <= 1'b0;
         end else if (adv) begin
            q_ff[j] <= q_in[j];
         end
      end
   end

   // exponent scaling with saturation
   always_comb begin
      logic [5:0]  sh;
      logic [70:0] wide;
      logic [63:0] lim;
      logic [63:0] half;
      sh   = '0;
      wide = '0;
      half = '0;
      lim  = q_ff[Div2Steps].neg ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
      f3_in.vld = q_ff[Div2Steps].vld;
      f3_in.neg = q_ff[Div2Steps].neg;
      f3_in.sat = 1'b0;
      f3_in.mag = q_ff[Div2Steps].mag;
      if (!q_ff[Div2Steps].is_small) begin
         if (q_ff[Div2Steps].k >= ExpShift) begin
            sh   = q_ff[Div2Steps].k - ExpShift;
            wide = 71'(q_ff[Div2Steps].quo) << sh;
            if (wide > 71'(lim)) begin
               f3_in.sat = 1'b1;
               f3_in.mag = lim;
            end else begin
               f3_in.mag = wide[63:0];
            end
         end else begin
            sh        = ExpShift - q_ff[Div2Steps].k;
            half      = 64'd1 << (sh - 6'd1);
            f3_in.mag = (64'(q_ff[Div2Steps].quo) + half) >> sh;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f3_ff.vld <= 1'b0;
      end else if (adv) begin
         f3_ff <= f3_in;
      end
   end

   // sign and output register
   always_comb begin
      o_in     = f3_ff;
      o_in.mag = f3_ff.neg ? (64'd0 - f3_ff.mag) : f3_ff.mag;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         o_ff.vld <= 1'b0;
      end else if (adv) begin
         o_ff <= o_in;
      end
   end

   assign rsp_valid     = o_ff.vld;
   assign rsp_i1_value  = $signed(o_ff.mag);
   assign rsp_saturated = o_ff.sat;

endmodule
